// ===== hdl/mbq_pkg.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// mbq_pkg
// Shared types, constants and helpers of the multichannel biquad filter.
// ---------------------------------------------------------------------------
package mbq_pkg;

  localparam int NUM_CHANNELS = 5;
  localparam int CH_W         = 3;
  localparam int CH_AW        = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
  localparam int SMP_W        = 16;
  localparam int COEF_W       = 18;
  localparam int ACC_W        = 32;
  localparam int PROD_W       = COEF_W + ACC_W;
  localparam int FRAC_W       = 14;
  localparam int NUM_COEF     = 6;
  localparam int REG_IDX_W    = 3;

  // coefficient register indexes
  localparam logic [REG_IDX_W-1:0] REG_A0 = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_A1 = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_A2 = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_B1 = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_B2 = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_B0 = 3'd5;

  localparam logic signed [COEF_W-1:0] Q14_ONE = 18'sd16384;

  // sequencer steps
  localparam int STEP_W = 3;
  localparam logic [STEP_W-1:0] STEP_A0    = 3'd0;
  localparam logic [STEP_W-1:0] STEP_A1    = 3'd1;
  localparam logic [STEP_W-1:0] STEP_A2    = 3'd2;
  localparam logic [STEP_W-1:0] STEP_B1    = 3'd3;
  localparam logic [STEP_W-1:0] STEP_B2    = 3'd4;
  localparam logic [STEP_W-1:0] STEP_DRAIN = 3'd5;
  localparam logic [STEP_W-1:0] STEP_GAIN  = 3'd6;
  localparam logic [STEP_W-1:0] STEP_DONE  = 3'd7;

  typedef struct packed {
    logic [CH_W-1:0]         channel;
    logic signed [SMP_W-1:0] sample;
  } in_word_t;

  typedef struct packed {
    logic [CH_W-1:0]         out_channel;
    logic signed [SMP_W-1:0] filtered;
  } out_word_t;

  // accumulator controls for the shared MAC
  typedef struct packed {
    logic load;
    logic add;
    logic sub;
  } mac_ctl_t;

  // history write request
  typedef struct packed {
    logic                    en;
    logic [CH_AW-1:0]        idx;
    logic signed [SMP_W-1:0] sample;
    logic signed [ACC_W-1:0] y0;
  } hist_wr_t;

  // raw sample -> Q14 word (sample * 2^14)
  function automatic logic signed [ACC_W-1:0] to_q14(input logic signed [SMP_W-1:0] s);
    return {{(ACC_W-SMP_W-FRAC_W){s[SMP_W-1]}}, s, {FRAC_W{1'b0}}};
  endfunction

  // Q14 word -> 16-bit sample, arithmetic shift then saturate
  function automatic logic signed [SMP_W-1:0] q14_sat(input logic signed [ACC_W-1:0] y);
    logic [ACC_W-FRAC_W-1:0] ys;
    ys = y[ACC_W-1:FRAC_W];
    if (ys[ACC_W-FRAC_W-1:SMP_W-1] == {(ACC_W-FRAC_W-SMP_W+1){1'b0}} ||
        ys[ACC_W-FRAC_W-1:SMP_W-1] == {(ACC_W-FRAC_W-SMP_W+1){1'b1}}) begin
      return ys[SMP_W-1:0];
    end
    return ys[ACC_W-FRAC_W-1] ? {1'b1, {(SMP_W-1){1'b0}}} : {1'b0, {(SMP_W-1){1'b1}}};
  endfunction

endpackage

// ===== hdl/multichannel_biquad_iir_filter_top.sv =====
`timescale 1ns / 1ps
// Sequence: a valid channel's word steps A0, A1, A2, B1, B2, DRAIN, GAIN, DONE; an
//   out-of-range channel goes straight to DONE and shows on out_* with filtered = 0.
// One word is taken at a time, and DONE waits for a free output register. The steps
//   serve six dependent products on one shared 18x32 multiplier, then a drain, then the gain.
// Reset (rst_n, synchronous, active low): coefficients return to a0 = b0 = 1.0 (Q14),
//   the others to 0; all channel histories clear to zero; no word is pending.
// ---------------------------------------------------------------------------
// multichannel_biquad_iir_filter_top
// Five-channel Q14 biquad: sequencer, coefficient registers, output register.
// ---------------------------------------------------------------------------
module multichannel_biquad_iir_filter_top (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  mbq_pkg::in_word_t                    in_data,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output mbq_pkg::out_word_t                   out_data,
  input  logic                                 cfg_wr_en,
  input  logic [mbq_pkg::REG_IDX_W-1:0]        cfg_index,
  input  logic [mbq_pkg::COEF_W-1:0]           cfg_wdata
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_RUN  = 1'b1;

  logic                                state_r, state_nxt;
  logic [mbq_pkg::STEP_W-1:0]          step_r, step_nxt;
  logic [mbq_pkg::CH_W-1:0]            chan_r;
  logic signed [mbq_pkg::SMP_W-1:0]    samp_r;
  logic                                bad_r;
  logic signed [mbq_pkg::COEF_W-1:0]   coef_r [mbq_pkg::NUM_COEF];
  logic                                out_valid_r;
  mbq_pkg::out_word_t                  out_data_r;

  logic                                accept;
  logic                                finish;
  logic signed [mbq_pkg::COEF_W-1:0]   mul_coef;
  logic signed [mbq_pkg::ACC_W-1:0]    mul_opnd;
  mbq_pkg::mac_ctl_t                   mac_ctl;
  logic signed [mbq_pkg::ACC_W-1:0]    prod_q14;
  logic signed [mbq_pkg::ACC_W-1:0]    acc;
  mbq_pkg::hist_wr_t                   hist_wr;
  logic signed [mbq_pkg::SMP_W-1:0]    x1, x2;
  logic signed [mbq_pkg::ACC_W-1:0]    y1, y2;

  assign in_ready  = (state_r == ST_IDLE);
  assign accept    = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // last step completes only once the output register is free
  assign finish = (state_r == ST_RUN) && (step_r == mbq_pkg::STEP_DONE) &&
                  (!out_valid_r || out_ready);

  // coefficient registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < mbq_pkg::NUM_COEF; i++) begin
        coef_r[i] <= (i == int'(mbq_pkg::REG_A0) || i == int'(mbq_pkg::REG_B0)) ?
                     mbq_pkg::Q14_ONE : '0;
      end
    end else if (cfg_wr_en && (int'(cfg_index) < mbq_pkg::NUM_COEF)) begin
      coef_r[cfg_index] <= cfg_wdata;
    end
  end

  // sequencer: one product issued per step, accumulated the step after
  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    if (state_r == ST_IDLE) begin
      if (accept) begin
        state_nxt = ST_RUN;
        // out-of-range channel skips the arithmetic entirely
        step_nxt  = (int'(in_data.channel) >= mbq_pkg::NUM_CHANNELS) ?
                    mbq_pkg::STEP_DONE : mbq_pkg::STEP_A0;
      end
    end else begin
      if (step_r != mbq_pkg::STEP_DONE) begin
        step_nxt = step_r + 1'b1;
      end else if (finish) begin
        state_nxt = ST_IDLE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      step_r  <= mbq_pkg::STEP_A0;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
    end
  end

  // hold the accepted word
  always_ff @(posedge clk) begin
    if (accept) begin
      chan_r <= in_data.channel;
      samp_r <= in_data.sample;
      bad_r  <= (int'(in_data.channel) >= mbq_pkg::NUM_CHANNELS);
    end
  end

  // operand selection for the shared multiplier
  always_comb begin
    case (step_r)
      mbq_pkg::STEP_A0: begin
        mul_coef = coef_r[mbq_pkg::REG_A0];
        mul_opnd = mbq_pkg::to_q14(samp_r);
      end
      mbq_pkg::STEP_A1: begin
        mul_coef = coef_r[mbq_pkg::REG_A1];
        mul_opnd = mbq_pkg::to_q14(x1);
      end
      mbq_pkg::STEP_A2: begin
        mul_coef = coef_r[mbq_pkg::REG_A2];
        mul_opnd = mbq_pkg::to_q14(x2);
      end
      mbq_pkg::STEP_B1: begin
        mul_coef = coef_r[mbq_pkg::REG_B1];
        mul_opnd = y1;
      end
      mbq_pkg::STEP_B2: begin
        mul_coef = coef_r[mbq_pkg::REG_B2];
        mul_opnd = y2;
      end
      default: begin
        // final gain on the completed sum
        mul_coef = coef_r[mbq_pkg::REG_B0];
        mul_opnd = acc;
      end
    endcase
  end

  // product of step k lands in the accumulator at step k+1
  always_comb begin
    mac_ctl.load = (state_r == ST_RUN) && (step_r == mbq_pkg::STEP_A1);
    mac_ctl.add  = (state_r == ST_RUN) &&
                   (step_r == mbq_pkg::STEP_A2 || step_r == mbq_pkg::STEP_B1);
    mac_ctl.sub  = (state_r == ST_RUN) &&
                   (step_r == mbq_pkg::STEP_B2 || step_r == mbq_pkg::STEP_DRAIN);
  end

  mbq_mac u_mac (
    .clk      (clk),
    .coef     (mul_coef),
    .opnd     (mul_opnd),
    .ctl      (mac_ctl),
    .prod_q14 (prod_q14),
    .acc      (acc)
  );

  // at the last step the gain product is the new y0
  always_comb begin
    hist_wr.en     = finish && !bad_r;
    hist_wr.idx    = chan_r[mbq_pkg::CH_AW-1:0];
    hist_wr.sample = samp_r;
    hist_wr.y0     = prod_q14;
  end

  mbq_hist u_hist (
    .clk    (clk),
    .rst_n  (rst_n),
    .rd_idx (chan_r[mbq_pkg::CH_AW-1:0]),
    .wr     (hist_wr),
    .x1     (x1),
    .x2     (x2),
    .y1     (y1),
    .y2     (y2)
  );

  // output register: load on finish, drop when taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (finish) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (finish) begin
      out_data_r.out_channel <= chan_r;
      out_data_r.filtered    <= bad_r ? '0 : mbq_pkg::q14_sat(prod_q14);
    end
  end

endmodule

// ===== hdl/mbq_mac.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// mbq_mac
// Shared Q14 multiplier with registered product and wrapping accumulator.
// ---------------------------------------------------------------------------
module mbq_mac (
  input  logic                                clk,
  input  logic signed [mbq_pkg::COEF_W-1:0]   coef,
  input  logic signed [mbq_pkg::ACC_W-1:0]    opnd,
  input  mbq_pkg::mac_ctl_t                   ctl,
  output logic signed [mbq_pkg::ACC_W-1:0]    prod_q14,
  output logic signed [mbq_pkg::ACC_W-1:0]    acc
);

  logic signed [mbq_pkg::PROD_W-1:0] prod_r;
  logic signed [mbq_pkg::ACC_W-1:0]  acc_r;
  logic signed [mbq_pkg::ACC_W-1:0]  acc_nxt;

  // (a*b) >> 14, wrapped to 32 bits
  assign prod_q14 = prod_r[mbq_pkg::ACC_W+mbq_pkg::FRAC_W-1:mbq_pkg::FRAC_W];
  assign acc      = acc_r;

  always_comb begin
    acc_nxt = acc_r;
    if (ctl.load) begin
      acc_nxt = prod_q14;
    end else if (ctl.add) begin
      acc_nxt = acc_r + prod_q14;
    end else if (ctl.sub) begin
      acc_nxt = acc_r - prod_q14;
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= coef * opnd;
    acc_r  <= acc_nxt;
  end

endmodule

// ===== hdl/mbq_hist.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// mbq_hist
// Per-channel input and output histories, two taps each, cleared on reset.
// ---------------------------------------------------------------------------
module mbq_hist (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic [mbq_pkg::CH_AW-1:0]          rd_idx,
  input  mbq_pkg::hist_wr_t                  wr,
  output logic signed [mbq_pkg::SMP_W-1:0]   x1,
  output logic signed [mbq_pkg::SMP_W-1:0]   x2,
  output logic signed [mbq_pkg::ACC_W-1:0]   y1,
  output logic signed [mbq_pkg::ACC_W-1:0]   y2
);

  logic signed [mbq_pkg::SMP_W-1:0] x1_r [mbq_pkg::NUM_CHANNELS];
  logic signed [mbq_pkg::SMP_W-1:0] x2_r [mbq_pkg::NUM_CHANNELS];
  logic signed [mbq_pkg::ACC_W-1:0] y1_r [mbq_pkg::NUM_CHANNELS];
  logic signed [mbq_pkg::ACC_W-1:0] y2_r [mbq_pkg::NUM_CHANNELS];

  assign x1 = x1_r[rd_idx];
  assign x2 = x2_r[rd_idx];
  assign y1 = y1_r[rd_idx];
  assign y2 = y2_r[rd_idx];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < mbq_pkg::NUM_CHANNELS; i++) begin
        x1_r[i] <= '0;
        x2_r[i] <= '0;
        y1_r[i] <= '0;
        y2_r[i] <= '0;
      end
    end else if (wr.en) begin
      // shift the channel's taps
      x2_r[wr.idx] <= x1_r[wr.idx];
      x1_r[wr.idx] <= wr.sample;
      y2_r[wr.idx] <= y1_r[wr.idx];
      y1_r[wr.idx] <= wr.y0;
    end
  end

endmodule
